// ===== rtl/rrts_pkg.sv =====
package rrts_pkg;

    // Field widths of the event and result beats
    localparam int ACT_W  = 3;
    localparam int TID_W  = 7;
    localparam int TIME_W = 32;
    localparam int CHAR_W = 9;
    localparam int ST_W   = 3;
    localparam int RES_W  = 3;

    // Event codes
    localparam logic [ACT_W-1:0] ACT_CREATE = 3'd0;
    localparam logic [ACT_W-1:0] ACT_EXIT   = 3'd1;
    localparam logic [ACT_W-1:0] ACT_WAIT   = 3'd2;
    localparam logic [ACT_W-1:0] ACT_SLEEP  = 3'd3;
    localparam logic [ACT_W-1:0] ACT_READ   = 3'd4;
    localparam logic [ACT_W-1:0] ACT_POLL   = 3'd5;

    // Per-task state codes
    localparam logic [ST_W-1:0] ST_RUNNABLE   = 3'd0;
    localparam logic [ST_W-1:0] ST_WAITING    = 3'd1;
    localparam logic [ST_W-1:0] ST_SLEEPING   = 3'd2;
    localparam logic [ST_W-1:0] ST_WAIT_INPUT = 3'd3;
    localparam logic [ST_W-1:0] ST_DONE       = 3'd4;

    // Result status codes
    localparam logic [RES_W-1:0] RES_CREATED  = 3'd0;
    localparam logic [RES_W-1:0] RES_FULL     = 3'd1;
    localparam logic [RES_W-1:0] RES_SWITCHED = 3'd2;
    localparam logic [RES_W-1:0] RES_CHAR     = 3'd3;
    localparam logic [RES_W-1:0] RES_NONE     = 3'd4;

    // What an event needs once its write is done
    typedef enum logic [1:0] {
        K_NONE,
        K_NOW,
        K_SCAN
    } t_kind;

    typedef struct packed {
        logic clear;
        logic capture;
        logic apply;
        logic scan;
        logic load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic  clr_last;
        t_kind kind;
        logic  hit;
        logic  drained;
        logic  out_free;
    } t_dp_sts;

endpackage

// ===== rtl/rrts_ram.sv =====
module rrts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== rtl/rrts_ctrl.sv =====
module rrts_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    output rrts_pkg::t_dp_cmd o_cmd,
    input  rrts_pkg::t_dp_sts i_sts
);

    import rrts_pkg::*;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_APPLY,
        S_SCAN,
        S_OUT
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clear = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_cmd.capture = i_in_valid;
                if (i_in_valid) begin
                    n_state = S_APPLY;
                end
            end
            S_APPLY: begin
                o_cmd.apply = 1'b1;
                case (i_sts.kind)
                    K_NOW:   n_state = S_OUT;
                    K_SCAN:  n_state = S_SCAN;
                    default: n_state = S_IDLE;
                endcase
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_sts.hit || i_sts.drained) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                o_cmd.load_out = i_sts.out_free;
                if (i_sts.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_CLEAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

endmodule

// ===== rtl/rrts_datapath.sv =====
module rrts_datapath #(
    parameter int TASK_SLOTS = 128
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  rrts_pkg::t_dp_cmd             i_cmd,
    output rrts_pkg::t_dp_sts             o_sts,
    input  logic [rrts_pkg::ACT_W-1:0]    i_action,
    input  logic [rrts_pkg::TID_W-1:0]    i_target_task,
    input  logic [rrts_pkg::TIME_W-1:0]   i_sleep_ms,
    input  logic [rrts_pkg::TIME_W-1:0]   i_now_ms,
    input  logic                          i_char_valid,
    input  logic [rrts_pkg::CHAR_W-1:0]   i_char_code,
    input  logic                          i_out_stall,
    output logic                          o_out_valid,
    output logic [rrts_pkg::RES_W-1:0]    o_status,
    output logic [rrts_pkg::TID_W-1:0]    o_task_id,
    output logic [rrts_pkg::CHAR_W-1:0]   o_char_out,
    output logic                          o_char_out_valid
);

    import rrts_pkg::*;

    localparam int IW = $clog2(TASK_SLOTS);
    localparam int CW = $clog2(TASK_SLOTS + 1);

    // captured event
    logic [ACT_W-1:0]  r_act;
    logic [TID_W-1:0]  r_target;
    logic [TIME_W-1:0] r_sleep_ms;
    logic [TIME_W-1:0] r_now;
    logic              r_cvalid;
    logic [CHAR_W-1:0] r_code;

    logic [IW-1:0] r_running;
    logic [CW-1:0] r_count;
    logic [IW-1:0] r_clr_idx;

    // scan issue and two-stage lookup pipe
    logic [IW-1:0]   r_scan_idx;
    logic [CW-1:0]   r_scan_left;
    logic            r_p1_valid;
    logic [IW-1:0]   r_p1_idx;
    logic            r_p2_valid;
    logic [IW-1:0]   r_p2_idx;
    logic [ST_W-1:0] r_p2_st;
    logic            r_p2_wake_ok;
    logic            r_p2_aw_ok;

    logic [RES_W-1:0]  r_res_status;
    logic [IW-1:0]     r_res_id;
    logic [CHAR_W-1:0] r_res_char;
    logic              r_res_cv;

    logic              r_out_valid;
    logic [RES_W-1:0]  r_out_status;
    logic [TID_W-1:0]  r_out_id;
    logic [CHAR_W-1:0] r_out_char;
    logic              r_out_cv;

    logic              cnt_full;
    t_kind             kind;
    logic              issue;
    logic              hit;
    logic              drained;
    logic              out_free;
    logic              p2_ok;
    logic              p2_gotc;

    logic              st_we;
    logic [IW-1:0]     st_wa;
    logic [ST_W-1:0]   st_wd;
    logic              wk_we;
    logic              aw_we;
    logic [ST_W-1:0]   sa_rd;
    logic [ST_W-1:0]   sb_rd;
    logic [TIME_W-1:0] wk_rd;
    logic [TID_W-1:0]  aw_rd;
    logic [IW-1:0]     sb_addr;

    function automatic logic [IW-1:0] f_next(input logic [IW-1:0] idx,
                                             input logic [CW-1:0] cnt);
        logic [CW-1:0] inc;
        inc = CW'(idx) + CW'(1);
        return (inc >= cnt) ? '0 : IW'(inc);
    endfunction

    assign cnt_full = (r_count >= CW'(TASK_SLOTS));

    always_comb begin
        case (r_act)
            ACT_CREATE: kind = K_NOW;
            ACT_READ:   kind = r_cvalid ? K_NOW : K_SCAN;
            ACT_EXIT:   kind = K_SCAN;
            ACT_WAIT:   kind = K_SCAN;
            ACT_SLEEP:  kind = K_SCAN;
            ACT_POLL:   kind = K_SCAN;
            default:    kind = K_NONE;
        endcase
    end

    // state write port: clear sweep, event write, or marking the chosen slot runnable
    always_comb begin
        st_we = 1'b0;
        st_wa = r_running;
        st_wd = ST_RUNNABLE;
        if (i_cmd.clear) begin
            st_we = 1'b1;
            st_wa = r_clr_idx;
        end else if (i_cmd.apply) begin
            case (r_act)
                ACT_CREATE: begin
                    st_we = !cnt_full;
                    st_wa = IW'(r_count);
                end
                ACT_EXIT: begin
                    st_we = 1'b1;
                    st_wd = ST_DONE;
                end
                ACT_WAIT: begin
                    st_we = 1'b1;
                    st_wd = ST_WAITING;
                end
                ACT_SLEEP: begin
                    st_we = 1'b1;
                    st_wd = ST_SLEEPING;
                end
                ACT_READ: begin
                    st_we = !r_cvalid;
                    st_wd = ST_WAIT_INPUT;
                end
                default: st_we = 1'b0;
            endcase
        end else if (i_cmd.scan && hit) begin
            st_we = 1'b1;
            st_wa = r_p2_idx;
        end
    end

    assign wk_we   = i_cmd.apply && (r_act == ACT_SLEEP);
    assign aw_we   = i_cmd.apply && (r_act == ACT_WAIT);
    assign sb_addr = IW'(aw_rd);

    // two copies of the state table: one for the candidate, one for its awaited task
    rrts_ram #(.WIDTH(ST_W), .DEPTH(TASK_SLOTS)) u_st_a (
        .i_clk     (i_clk),
        .i_wr_en   (st_we),
        .i_wr_addr (st_wa),
        .i_wr_data (st_wd),
        .i_rd_addr (r_scan_idx),
        .o_rd_data (sa_rd)
    );

    rrts_ram #(.WIDTH(ST_W), .DEPTH(TASK_SLOTS)) u_st_b (
        .i_clk     (i_clk),
        .i_wr_en   (st_we),
        .i_wr_addr (st_wa),
        .i_wr_data (st_wd),
        .i_rd_addr (sb_addr),
        .o_rd_data (sb_rd)
    );

    rrts_ram #(.WIDTH(TIME_W), .DEPTH(TASK_SLOTS)) u_wake (
        .i_clk     (i_clk),
        .i_wr_en   (wk_we),
        .i_wr_addr (r_running),
        .i_wr_data (r_now + r_sleep_ms),
        .i_rd_addr (r_scan_idx),
        .o_rd_data (wk_rd)
    );

    rrts_ram #(.WIDTH(TID_W), .DEPTH(TASK_SLOTS)) u_await (
        .i_clk     (i_clk),
        .i_wr_en   (aw_we),
        .i_wr_addr (r_running),
        .i_wr_data (r_target),
        .i_rd_addr (r_scan_idx),
        .o_rd_data (aw_rd)
    );

    always_comb begin
        p2_ok   = 1'b0;
        p2_gotc = 1'b0;
        case (r_p2_st)
            ST_RUNNABLE:   p2_ok = 1'b1;
            ST_WAITING:    p2_ok = r_p2_aw_ok && (sb_rd == ST_DONE);
            ST_SLEEPING:   p2_ok = r_p2_wake_ok;
            ST_WAIT_INPUT: begin
                p2_ok   = r_cvalid;
                p2_gotc = r_cvalid;
            end
            default:       p2_ok = 1'b0;
        endcase
    end

    assign hit      = r_p2_valid && p2_ok;
    assign issue    = i_cmd.scan && (r_scan_left != '0) && !hit;
    assign drained  = (r_scan_left == '0) && !r_p1_valid && !r_p2_valid;
    assign out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_running   <= '0;
            r_count     <= CW'(1);
            r_clr_idx   <= '0;
            r_scan_idx  <= '0;
            r_scan_left <= '0;
            r_p1_valid  <= 1'b0;
            r_p2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.clear) begin
                r_clr_idx <= r_clr_idx + IW'(1);
            end
            if (i_cmd.apply && (r_act == ACT_CREATE) && !cnt_full) begin
                r_count <= r_count + CW'(1);
            end
            if (i_cmd.scan && hit) begin
                r_running <= r_p2_idx;
            end
            // search starts after the running task and ends on it
            if (i_cmd.apply) begin
                r_scan_idx  <= f_next(r_running, r_count);
                r_scan_left <= r_count;
            end else if (issue) begin
                r_scan_idx  <= f_next(r_scan_idx, r_count);
                r_scan_left <= r_scan_left - CW'(1);
            end
            r_p1_valid <= issue;
            r_p2_valid <= i_cmd.scan && r_p1_valid && !hit;
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_act      <= i_action;
            r_target   <= i_target_task;
            r_sleep_ms <= i_sleep_ms;
            r_now      <= i_now_ms;
            r_cvalid   <= i_char_valid;
            r_code     <= i_char_code;
        end

        r_p1_idx     <= r_scan_idx;
        r_p2_idx     <= r_p1_idx;
        r_p2_st      <= sa_rd;
        r_p2_wake_ok <= (r_now >= wk_rd);
        r_p2_aw_ok   <= (32'(aw_rd) < 32'(TASK_SLOTS));

        if (i_cmd.apply) begin
            if (r_act == ACT_CREATE) begin
                r_res_status <= cnt_full ? RES_FULL : RES_CREATED;
                r_res_id     <= cnt_full ? '0 : IW'(r_count);
                r_res_char   <= '0;
                r_res_cv     <= 1'b0;
            end else begin
                // read with a character ready; scan events overwrite this later
                r_res_status <= RES_CHAR;
                r_res_id     <= r_running;
                r_res_char   <= r_code;
                r_res_cv     <= 1'b1;
            end
        end else if (i_cmd.scan && hit) begin
            r_res_status <= RES_SWITCHED;
            r_res_id     <= r_p2_idx;
            r_res_char   <= p2_gotc ? r_code : '0;
            r_res_cv     <= p2_gotc;
        end else if (i_cmd.scan && drained) begin
            r_res_status <= RES_NONE;
            r_res_id     <= r_running;
            r_res_char   <= '0;
            r_res_cv     <= 1'b0;
        end

        if (i_cmd.load_out) begin
            r_out_status <= r_res_status;
            r_out_id     <= TID_W'(r_res_id);
            r_out_char   <= r_res_char;
            r_out_cv     <= r_res_cv;
        end
    end

    always_comb begin
        o_sts          = '0;
        o_sts.clr_last = (r_clr_idx == IW'(TASK_SLOTS - 1));
        o_sts.kind     = kind;
        o_sts.hit      = hit;
        o_sts.drained  = drained;
        o_sts.out_free = out_free;
    end

    assign o_out_valid      = r_out_valid;
    assign o_status         = r_out_status;
    assign o_task_id        = r_out_id;
    assign o_char_out       = r_out_char;
    assign o_char_out_valid = r_out_cv;

endmodule

// ===== rtl/round_robin_task_scheduler_top.sv =====
// Channel   Handshake                   Beat contents
// event     i_in_valid / o_in_stall     i_action, i_target_task, i_sleep_ms, i_now_ms,
//                                       i_char_valid, i_char_code
// result    o_out_valid / i_out_stall   o_status, o_task_id, o_char_out, o_char_out_valid
//
// One event at a time. Create, and read with a character ready, give their result
// without a slot search; an event that reschedules waits on the slot search, which
// steps through the state memory one table entry a cycle. After reset the state
// table is swept to runnable with o_in_stall high. Unknown events give no result
// beat. A held result beat does not block the next event; only its own result waits
// for the output register to drain.
module round_robin_task_scheduler_top #(
    parameter int TASK_SLOTS = 128
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [rrts_pkg::ACT_W-1:0]  i_action,
    input  logic [rrts_pkg::TID_W-1:0]  i_target_task,
    input  logic [rrts_pkg::TIME_W-1:0] i_sleep_ms,
    input  logic [rrts_pkg::TIME_W-1:0] i_now_ms,
    input  logic                        i_char_valid,
    input  logic [rrts_pkg::CHAR_W-1:0] i_char_code,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [rrts_pkg::RES_W-1:0]  o_status,
    output logic [rrts_pkg::TID_W-1:0]  o_task_id,
    output logic [rrts_pkg::CHAR_W-1:0] o_char_out,
    output logic                        o_char_out_valid
);

    import rrts_pkg::*;

    t_dp_cmd cmd;   // controller -> datapath
    t_dp_sts sts;   // datapath -> controller

    // Sequencer: clear sweep, capture, event write, search, result hand-off
    rrts_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .o_cmd      (cmd),
        .i_sts      (sts)
    );

    // Task tables, search pipe, result and output registers
    rrts_datapath #(.TASK_SLOTS(TASK_SLOTS)) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .i_action         (i_action),
        .i_target_task    (i_target_task),
        .i_sleep_ms       (i_sleep_ms),
        .i_now_ms         (i_now_ms),
        .i_char_valid     (i_char_valid),
        .i_char_code      (i_char_code),
        .i_out_stall      (i_out_stall),
        .o_out_valid      (o_out_valid),
        .o_status         (o_status),
        .o_task_id        (o_task_id),
        .o_char_out       (o_char_out),
        .o_char_out_valid (o_char_out_valid)
    );

endmodule

// ===== rtl/rrts_checker.sv =====
module rrts_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_in_valid,
    input logic                        o_in_stall,
    input logic                        o_out_valid,
    input logic                        i_out_stall,
    input logic [rrts_pkg::RES_W-1:0]  o_status,
    input logic [rrts_pkg::TID_W-1:0]  o_task_id,
    input logic [rrts_pkg::CHAR_W-1:0] o_char_out,
    input logic                        o_char_out_valid
);

    import rrts_pkg::*;

    // result beat held while stalled
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_status)
            && $stable(o_task_id) && $stable(o_char_out) && $stable(o_char_out_valid))
        else $error("result beat changed while stalled");

    // table sweep keeps events out after reset
    a_rst_stall: assert property (@(posedge i_clk)
        !i_rst_n |=> o_in_stall)
        else $error("event channel open straight after reset");

    // one event in flight
    a_one_event: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("second event taken before first was processed");

    a_char_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_char_out_valid |-> (o_status == RES_SWITCHED)
            || (o_status == RES_CHAR))
        else $error("character delivered with wrong status");

    a_char_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status == RES_CHAR) |-> o_char_out_valid)
        else $error("read result without a character");

endmodule

bind round_robin_task_scheduler_top rrts_checker u_rrts_checker (.*);

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps

// Scheduler decision core: event beats in, one result beat per known event out.
// The driver pulls events from a backlog built up front, and the scheduler model
// runs on each accepted beat. The monitor checks every result beat, in order,
// against what the model logged. Both sides idle in short random bursts, except
// in the closing stretch.
module testbench;
    import rrts_pkg::*;

    localparam int SLOTS = 128;
    // The two codes the block must ignore
    localparam logic [ACT_W-1:0] ACT_BAD_LO = 3'd6;
    localparam logic [ACT_W-1:0] ACT_BAD_HI = 3'd7;

    typedef struct {
        logic [ACT_W-1:0]  act;
        logic [TID_W-1:0]  target;
        logic [TIME_W-1:0] sleep_ms;
        logic [TIME_W-1:0] now_ms;
        logic              cvalid;
        logic [CHAR_W-1:0] code;
        bit                hold;   // hold back until every owed result is in
        bit                calm;   // closing stretch, no idling on either side
    } t_evt;

    typedef struct packed {
        logic [RES_W-1:0]  status;
        logic [TID_W-1:0]  task_id;
        logic [CHAR_W-1:0] ch;
        logic              ch_valid;
    } t_result;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    // Event channel, driven by the testbench
    logic              ev_valid  = 1'b0;
    logic [ACT_W-1:0]  ev_action = '0;
    logic [TID_W-1:0]  ev_target = '0;
    logic [TIME_W-1:0] ev_sleep  = '0;
    logic [TIME_W-1:0] ev_now    = '0;
    logic              ev_cvalid = 1'b0;
    logic [CHAR_W-1:0] ev_code   = '0;
    logic              ev_stall;

    // Result channel
    logic              res_valid;
    logic              res_stall = 1'b0;
    logic [RES_W-1:0]  res_status;
    logic [TID_W-1:0]  res_task;
    logic [CHAR_W-1:0] res_char;
    logic              res_char_valid;

    // Scheduler model state
    logic [ST_W-1:0]   sched_state  [SLOTS];
    logic [TIME_W-1:0] sched_wake   [SLOTS];
    logic [TID_W-1:0]  sched_awaits [SLOTS];
    int unsigned       sched_running;
    int unsigned       sched_count;

    t_evt        ev_backlog[$];
    t_evt        ev_cur;
    t_result     due_results[$];   // logged in order, indexed by seen_count
    int unsigned due_count  = 0;   // NBA only, so both sides read a settled value
    int unsigned seen_count = 0;
    int unsigned fault_count = 0;
    bit          quiet = 1'b0;

    // Stimulus bookkeeping
    logic [TIME_W-1:0] stim_now   = '0;
    bit                next_hold  = 1'b0;
    int unsigned       made_tasks = 1;

    round_robin_task_scheduler_top #(
        .TASK_SLOTS(SLOTS)
    ) u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (ev_valid),
        .o_in_stall       (ev_stall),
        .i_action         (ev_action),
        .i_target_task    (ev_target),
        .i_sleep_ms       (ev_sleep),
        .i_now_ms         (ev_now),
        .i_char_valid     (ev_cvalid),
        .i_char_code      (ev_code),
        .o_out_valid      (res_valid),
        .i_out_stall      (res_stall),
        .o_status         (res_status),
        .o_task_id        (res_task),
        .o_char_out       (res_char),
        .o_char_out_valid (res_char_valid)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Scheduler model
    // ------------------------------------------------------------------

    // Round-robin search from running+1, wrapping, running slot tried last.
    // The chosen slot goes back to runnable; an input waiter takes the char.
    function automatic t_result pick_next(input t_evt e);
        int unsigned slot;
        bit          ok;
        t_result     r;
        slot = sched_running;
        r    = '0;
        for (int k = 0; k < sched_count; k++) begin
            slot = (slot + 1 >= sched_count) ? 0 : slot + 1;
            case (sched_state[slot])
                ST_RUNNABLE:   ok = 1'b1;
                // an uncreated slot reads as runnable, so never as done
                ST_WAITING:    ok = (sched_state[sched_awaits[slot]] == ST_DONE);
                ST_SLEEPING:   ok = (e.now_ms >= sched_wake[slot]);
                ST_WAIT_INPUT: ok = e.cvalid;
                default:       ok = 1'b0;
            endcase
            if (ok) begin
                if (sched_state[slot] == ST_WAIT_INPUT) begin
                    r.ch       = e.code;
                    r.ch_valid = 1'b1;
                end
                sched_state[slot] = ST_RUNNABLE;
                sched_running     = slot;
                r.status          = RES_SWITCHED;
                r.task_id         = TID_W'(slot);
                return r;
            end
        end
        // nothing eligible: running task kept, its new state stands
        r.status  = RES_NONE;
        r.task_id = TID_W'(sched_running);
        return r;
    endfunction

    // Applies one accepted event; returns 0 for the ignored codes.
    function automatic bit take_event(input t_evt e, output t_result r);
        int unsigned cur;
        bit          has;
        cur = sched_running;
        has = 1'b1;
        r   = '0;
        case (e.act)
            ACT_CREATE: begin
                if (sched_count >= SLOTS) begin
                    r.status = RES_FULL;
                end else begin
                    sched_state[sched_count] = ST_RUNNABLE;
                    r.status  = RES_CREATED;
                    r.task_id = TID_W'(sched_count);
                    sched_count++;
                end
            end
            ACT_EXIT: begin
                sched_state[cur] = ST_DONE;
                r = pick_next(e);
            end
            ACT_WAIT: begin
                sched_state[cur]  = ST_WAITING;
                sched_awaits[cur] = e.target;
                r = pick_next(e);
            end
            ACT_SLEEP: begin
                sched_state[cur] = ST_SLEEPING;
                sched_wake[cur]  = e.now_ms + e.sleep_ms;   // wraps mod 2^32
                r = pick_next(e);
            end
            ACT_READ: begin
                if (e.cvalid) begin
                    // char handed straight back, no state change at all
                    r.status   = RES_CHAR;
                    r.task_id  = TID_W'(cur);
                    r.ch       = e.code;
                    r.ch_valid = 1'b1;
                end else begin
                    sched_state[cur] = ST_WAIT_INPUT;
                    r = pick_next(e);
                end
            end
            ACT_POLL: r = pick_next(e);
            default:  has = 1'b0;
        endcase
        return has;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------

    task automatic queue_event(input logic [ACT_W-1:0] act, input logic [TID_W-1:0] tgt,
                               input logic [TIME_W-1:0] ms, input logic cv,
                               input logic [CHAR_W-1:0] ch, input bit calm);
        t_evt e;
        e.act      = act;
        e.target   = tgt;
        e.sleep_ms = ms;
        e.now_ms   = stim_now;
        e.cvalid   = cv;
        e.code     = ch;
        e.hold     = next_hold;
        e.calm     = calm;
        next_hold  = 1'b0;
        ev_backlog.push_back(e);
        if (act == ACT_CREATE && made_tasks < SLOTS)
            made_tasks++;
    endtask

    // Time creeps forward (pinned at the top once there); sleeps are mostly
    // short so sleepers come back, with the odd zero, huge or wrapping one.
    task automatic random_event(input bit calm);
        int unsigned       pick;
        logic [ACT_W-1:0]  act;
        logic [TID_W-1:0]  tgt;
        logic [TIME_W-1:0] ms;
        if (32'hFFFF_FFFF - stim_now < 40)
            stim_now = 32'hFFFF_FFFF;
        else
            stim_now = stim_now + $urandom_range(0, 39);
        pick = $urandom_range(0, 99);
        if (pick < 8)
            act = ACT_CREATE;
        else if (pick < 18)
            act = ACT_EXIT;
        else if (pick < 32)
            act = ACT_WAIT;
        else if (pick < 52)
            act = ACT_SLEEP;
        else if (pick < 74)
            act = ACT_READ;
        else if (pick < 97)
            act = ACT_POLL;
        else
            act = $urandom_range(0, 1) ? ACT_BAD_HI : ACT_BAD_LO;
        if ($urandom_range(0, 4) == 0)
            tgt = TID_W'($urandom_range(0, SLOTS - 1));
        else
            tgt = TID_W'($urandom_range(0, made_tasks - 1));
        case ($urandom_range(0, 9))
            0:       ms = '0;
            1:       ms = $urandom;
            2:       ms = 32'hFFFF_FFFF - $urandom_range(0, 50);
            default: ms = $urandom_range(1, 300);
        endcase
        queue_event(act, tgt, ms, 1'($urandom_range(0, 1)),
                    CHAR_W'($urandom_range(0, 511)), calm);
    endtask

    initial begin
        for (int i = 0; i < SLOTS; i++)
            sched_state[i] = ST_RUNNABLE;
        sched_running = 0;
        sched_count   = 1;

        // Directed opening, walked through by hand from a lone task 0
        queue_event(ACT_POLL,   '0, '0, 1'b0, '0, 1'b0);   // lone task picked again
        queue_event(ACT_READ,   '1, '1, 1'b1, '1, 1'b0);   // char ready: back in place
        queue_event(ACT_READ,   '0, '0, 1'b0, '0, 1'b0);   // no char: none ready
        queue_event(ACT_POLL,   '0, '0, 1'b1, '0, 1'b0);   // reader resumes with code 0
        queue_event(ACT_CREATE, '1, '1, 1'b1, '1, 1'b0);
        queue_event(ACT_CREATE, '0, '0, 1'b0, '0, 1'b0);
        queue_event(ACT_CREATE, '0, '0, 1'b0, '0, 1'b0);
        queue_event(ACT_WAIT,   7'd2, '0, 1'b0, '0, 1'b0); // 0 waits on 2, go to 1
        queue_event(ACT_EXIT,   '0, '0, 1'b0, '0, 1'b0);   // 1 done, go to 2
        stim_now = 32'd100;
        queue_event(ACT_SLEEP,  '0, '1, 1'b0, '0, 1'b0);   // wake time wraps below now
        queue_event(ACT_SLEEP,  '0, 32'd1000, 1'b0, '0, 1'b0);  // 3 sleeps, 2 already due
        queue_event(ACT_EXIT,   '0, '0, 1'b0, '0, 1'b0);   // 2 done frees task 0
        queue_event(ACT_WAIT,   7'd127, '0, 1'b0, '0, 1'b0);    // uncreated slot, never done
        queue_event(ACT_READ,   '0, '0, 1'b1, 9'h0AA, 1'b0);    // char to a blocked task
        queue_event(ACT_BAD_LO, '1, '1, 1'b1, '1, 1'b0);   // ignored codes
        queue_event(ACT_BAD_HI, '0, '0, 1'b0, '0, 1'b0);
        stim_now = 32'd1100;
        queue_event(ACT_POLL,   '0, '0, 1'b0, '0, 1'b0);   // 3 wakes exactly on time
        queue_event(ACT_READ,   '0, '0, 1'b0, '0, 1'b0);   // 3 waits for input
        queue_event(ACT_POLL,   '0, '0, 1'b1, 9'h155, 1'b0);
        queue_event(ACT_SLEEP,  '0, '0, 1'b0, '0, 1'b0);   // zero sleep, due at once
        queue_event(ACT_CREATE, '0, '0, 1'b0, '0, 1'b0);
        queue_event(ACT_POLL,   '0, '0, 1'b0, '0, 1'b0);   // poll leaves a runnable task

        // Mixed traffic on a small table
        next_hold = 1'b1;
        repeat (400) random_event(1'b0);

        // Fill the table and push past it
        next_hold = 1'b1;
        repeat (110)
            queue_event(ACT_CREATE, TID_W'($urandom_range(0, 127)), $urandom,
                        1'($urandom_range(0, 1)), CHAR_W'($urandom_range(0, 511)), 1'b0);

        // Full table, time moved into the upper half, then to the very top
        stim_now = 32'h8000_0000 + $urandom_range(0, 32'h3FFF_FFFF);
        repeat (300) random_event(1'b0);
        stim_now = 32'hFFFF_F000;
        repeat (50) random_event(1'b0);
        repeat (100) random_event(1'b1);

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Sampled on the falling edge, clear of the rising-edge updates
        @(negedge i_clk);
        while (ev_backlog.size() != 0 || ev_valid || seen_count != due_count)
            @(negedge i_clk);
        // room for the longest rescan to finish; catch any stray beat
        repeat (200) @(negedge i_clk);
        if (fault_count == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

    initial begin
        #10_000_000;
        $display("testbench: done, errors");
        $finish;
    end

    // ------------------------------------------------------------------
    // Driver: event beats
    // ------------------------------------------------------------------
    int unsigned gap_left = 0;

    always @(posedge i_clk) begin
        bit          fire;
        bit          has;
        t_result     r;
        int unsigned owed;
        if (i_rst_n) begin
            fire = ev_valid && !ev_stall;
            has  = 1'b0;
            if (fire) begin
                has = take_event(ev_cur, r);
                if (has) begin
                    due_results.push_back(r);
                    due_count <= due_count + 1;
                end
            end
            owed = due_count + (has ? 1 : 0);
            if (!ev_valid || fire) begin
                if (gap_left > 0) begin
                    gap_left--;
                    ev_valid <= 1'b0;
                end else if (ev_backlog.size() != 0 && !ev_backlog[0].calm
                             && $urandom_range(0, 3) == 0) begin
                    gap_left = $urandom_range(0, 2);   // start an idle burst of random length
                    ev_valid <= 1'b0;
                end else if (ev_backlog.size() == 0
                             || (ev_backlog[0].hold && owed != seen_count)) begin
                    ev_valid <= 1'b0;
                end else begin
                    ev_cur     = ev_backlog.pop_front();
                    ev_valid  <= 1'b1;
                    ev_action <= ev_cur.act;
                    ev_target <= ev_cur.target;
                    ev_sleep  <= ev_cur.sleep_ms;
                    ev_now    <= ev_cur.now_ms;
                    ev_cvalid <= ev_cur.cvalid;
                    ev_code   <= ev_cur.code;
                    quiet     <= ev_cur.calm;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: result beats
    // ------------------------------------------------------------------
    int unsigned stall_left = 0;

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n) begin
            if (res_valid === 1'b1 && !res_stall) begin
                if (seen_count >= due_count) begin
                    if (fault_count < 10)
                        $display("result beat with nothing owed: status %0d task %0d char %0h/%0b",
                                 res_status, res_task, res_char, res_char_valid);
                    fault_count++;
                end else begin
                    want = due_results[seen_count];
                    if (res_status !== want.status || res_task !== want.task_id
                        || res_char !== want.ch || res_char_valid !== want.ch_valid) begin
                        if (fault_count < 10) begin
                            $write("result %0d: want status %0d task %0d char %0h/%0b,",
                                   seen_count, want.status, want.task_id, want.ch,
                                   want.ch_valid);
                            $display(" got status %0d task %0d char %0h/%0b",
                                     res_status, res_task, res_char, res_char_valid);
                        end
                        fault_count++;
                    end
                    seen_count <= seen_count + 1;
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                res_stall <= 1'b1;
            end else if (!quiet && $urandom_range(0, 4) == 0) begin
                stall_left = $urandom_range(0, 2);
                res_stall <= 1'b1;
            end else begin
                res_stall <= 1'b0;
            end
        end
    end

endmodule

// ===== round_robin_task_scheduler_top.f =====
rtl/rrts_pkg.sv
rtl/rrts_ram.sv
rtl/rrts_ctrl.sv
rtl/rrts_datapath.sv
rtl/round_robin_task_scheduler_top.sv
rtl/rrts_checker.sv
tb/testbench.sv
